>>> src/conv2d_zero_pad_element_assert.svh
// Assertion macros for the conv2d zero-pad block.
// Included by the top level; depends on nothing else.
`ifndef CONV2D_ZERO_PAD_ELEMENT_ASSERT_SVH
`define CONV2D_ZERO_PAD_ELEMENT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CV2D_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cv2d: implication failed");

// next-cycle implication, disabled while reset is low
`define CV2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cv2d: next-cycle implication failed");

`endif

>>> src/cv2d_pkg.sv
// Shared constants, codes and types for the conv2d zero-pad block.
// No dependencies.
package cv2d_pkg;

  localparam int MAX_DIM_DEF    = 64;
  localparam int MAX_KERNEL_DEF = 7;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int CMD_W      = 2;
  localparam int COORD_W    = 6;
  localparam int VAL_W      = 16;
  localparam int ACC_W      = 37;
  localparam int MDIM_W     = 7;
  localparam int KDIM_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  // signed window coordinate: covers -3 .. 63+6
  localparam int CRD_W      = 8;

  localparam logic [CMD_W-1:0] CMD_KRN_WR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_IMG_WR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 2'd3;

  localparam logic [MDIM_W-1:0] MATRIX_ROWS_RST = 7'd1;
  localparam logic [MDIM_W-1:0] MATRIX_COLS_RST = 7'd1;
  localparam logic [KDIM_W-1:0] KERNEL_ROWS_RST = 3'd3;
  localparam logic [KDIM_W-1:0] KERNEL_COLS_RST = 3'd3;

  typedef struct packed {
    logic [MDIM_W-1:0] mrows;
    logic [MDIM_W-1:0] mcols;
    logic [KDIM_W-1:0] krows;
    logic [KDIM_W-1:0] kcols;
  } cv2d_cfg_t;

  typedef struct packed {
    logic clr;
    logic tap_vld;
  } cv2d_mac_ctl_t;

endpackage

>>> src/cv2d_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on cv2d_pkg.
interface cv2d_in_if;
  import cv2d_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [COORD_W-1:0]        row;
  logic [COORD_W-1:0]        col;
  logic signed [VAL_W-1:0]   value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface cv2d_out_if;
  import cv2d_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [COORD_W-1:0]        out_row;
  logic [COORD_W-1:0]        out_col;
  logic signed [ACC_W-1:0]   filtered;

  modport source (output valid, out_row, out_col, filtered, input ready);
  modport sink   (input valid, out_row, out_col, filtered, output ready);
endinterface

>>> src/cv2d_store.sv
// Image and kernel memories: one write port and one registered read port each.
// Depends on nothing outside its parameters.
module cv2d_store #(
  parameter int MAX_DIM    = 64,
  parameter int MAX_KERNEL = 7,
  parameter int DATA_WIDTH = 16,
  parameter int IMG_AW     = $clog2(MAX_DIM * MAX_DIM),
  parameter int KRN_AW     = $clog2(MAX_KERNEL * MAX_KERNEL)
) (
  input  logic                         clk,
  input  logic                         img_we,
  input  logic [IMG_AW-1:0]            img_waddr,
  input  logic                         krn_we,
  input  logic [KRN_AW-1:0]            krn_waddr,
  input  logic [DATA_WIDTH-1:0]        wdata,
  input  logic [IMG_AW-1:0]            img_raddr,
  input  logic [KRN_AW-1:0]            krn_raddr,
  output logic signed [DATA_WIDTH-1:0] img_rdata,
  output logic signed [DATA_WIDTH-1:0] krn_rdata
);

  localparam int IMG_DEPTH = MAX_DIM * MAX_DIM;
  localparam int KRN_DEPTH = MAX_KERNEL * MAX_KERNEL;

  logic [DATA_WIDTH-1:0] img_mem [IMG_DEPTH];
  logic [DATA_WIDTH-1:0] krn_mem [KRN_DEPTH];

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[img_waddr] <= wdata;
    end
    img_rdata <= img_mem[img_raddr];
  end

  always_ff @(posedge clk) begin
    if (krn_we) begin
      krn_mem[krn_waddr] <= wdata;
    end
    krn_rdata <= krn_mem[krn_raddr];
  end

endmodule

>>> src/cv2d_mac.sv
// Shared multiply-accumulate: registered product, then 37-bit wrapping sum.
// Depends on cv2d_pkg.
module cv2d_mac #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cv2d_pkg::cv2d_mac_ctl_t           ctl,
  input  logic signed [DATA_WIDTH-1:0]      img_rdata,
  input  logic signed [DATA_WIDTH-1:0]      krn_rdata,
  output logic signed [cv2d_pkg::ACC_W-1:0] acc
);
  import cv2d_pkg::*;

  logic                           vld1_r;
  logic                           vld2_r;
  logic signed [2*DATA_WIDTH-1:0] prod_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        acc_nxt;

  // tap valid follows the memory read latency, then the product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= ctl.tap_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= img_rdata * krn_rdata;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (vld2_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

>>> src/cv2d_seq.sv
// Query sequencer: walks the kernel window one tap per cycle, clips taps
// outside the matrix and drives the memory read addresses. Depends on cv2d_pkg.
module cv2d_seq #(
  parameter int MAX_DIM    = 64,
  parameter int MAX_KERNEL = 7,
  parameter int IMG_AW     = $clog2(MAX_DIM * MAX_DIM),
  parameter int KRN_AW     = $clog2(MAX_KERNEL * MAX_KERNEL)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cv2d_pkg::cv2d_cfg_t           cfg,
  input  logic                          start,
  input  logic [cv2d_pkg::COORD_W-1:0]  row,
  input  logic [cv2d_pkg::COORD_W-1:0]  col,
  input  logic                          out_take,
  output logic                          in_rdy,
  output logic                          out_vld,
  output logic [cv2d_pkg::COORD_W-1:0]  out_row,
  output logic [cv2d_pkg::COORD_W-1:0]  out_col,
  output cv2d_pkg::cv2d_mac_ctl_t       ctl,
  output logic [IMG_AW-1:0]             img_raddr,
  output logic [KRN_AW-1:0]             krn_raddr
);
  import cv2d_pkg::*;

  localparam int KW       = $clog2(MAX_KERNEL);
  localparam int HALF_MAX = (MAX_KERNEL - 1) / 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt;
  logic [COORD_W-1:0]  col_r, col_nxt;
  logic [KW-1:0]       hr_r, hr_nxt;
  logic [KW-1:0]       hc_r, hc_nxt;
  logic [KW-1:0]       spr_r, spr_nxt;
  logic [KW-1:0]       spc_r, spc_nxt;
  logic [MDIM_W-1:0]   nr_r, nr_nxt;
  logic [MDIM_W-1:0]   nc_r, nc_nxt;
  logic [KW-1:0]       kr_r, kr_nxt;
  logic [KW-1:0]       kc_r, kc_nxt;
  logic                cnt_r, cnt_nxt;

  logic [KW-1:0]       hr_c, hc_c;
  logic [MDIM_W-1:0]   nr_c, nc_c;
  logic signed [CRD_W-1:0] r_c, c_c;
  logic                r_ok, c_ok, tap_ok;

  // half-widths saturate at the largest kernel; dimensions at MAX_DIM
  always_comb begin
    hr_c = (int'(cfg.krows >> 1) > HALF_MAX) ? KW'(HALF_MAX) : KW'(cfg.krows >> 1);
    hc_c = (int'(cfg.kcols >> 1) > HALF_MAX) ? KW'(HALF_MAX) : KW'(cfg.kcols >> 1);
    nr_c = (int'(cfg.mrows) > MAX_DIM) ? MDIM_W'(MAX_DIM) : cfg.mrows;
    nc_c = (int'(cfg.mcols) > MAX_DIM) ? MDIM_W'(MAX_DIM) : cfg.mcols;
  end

  always_comb begin
    r_c    = CRD_W'(row_r) + CRD_W'(kr_r) - CRD_W'(hr_r);
    c_c    = CRD_W'(col_r) + CRD_W'(kc_r) - CRD_W'(hc_r);
    r_ok   = !r_c[CRD_W-1] && (r_c < $signed({1'b0, nr_r}));
    c_ok   = !c_c[CRD_W-1] && (c_c < $signed({1'b0, nc_r}));
    tap_ok = (state_r == ST_RUN) && r_ok && c_ok;
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    hr_nxt    = hr_r;
    hc_nxt    = hc_r;
    spr_nxt   = spr_r;
    spc_nxt   = spc_r;
    nr_nxt    = nr_r;
    nc_nxt    = nc_r;
    kr_nxt    = kr_r;
    kc_nxt    = kc_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          row_nxt   = row;
          col_nxt   = col;
          hr_nxt    = hr_c;
          hc_nxt    = hc_c;
          spr_nxt   = KW'({hr_c, 1'b0});
          spc_nxt   = KW'({hc_c, 1'b0});
          nr_nxt    = nr_c;
          nc_nxt    = nc_c;
          kr_nxt    = '0;
          kc_nxt    = '0;
        end
      end
      ST_RUN: begin
        if (kc_r == spc_r) begin
          kc_nxt = '0;
          if (kr_r == spr_r) begin
            state_nxt = ST_DRAIN;
            cnt_nxt   = 1'b0;
          end else begin
            kr_nxt = kr_r + 1'b1;
          end
        end else begin
          kc_nxt = kc_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait out the product register, then the last accumulate
        if (cnt_r) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kr_r    <= '0;
      kc_r    <= '0;
      cnt_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kr_r    <= kr_nxt;
      kc_r    <= kc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
    hr_r  <= hr_nxt;
    hc_r  <= hc_nxt;
    spr_r <= spr_nxt;
    spc_r <= spc_nxt;
    nr_r  <= nr_nxt;
    nc_r  <= nc_nxt;
  end

  // clipped taps read image address 0 and are dropped by the accumulator
  assign img_raddr = tap_ok ? IMG_AW'(int'(r_c) * MAX_DIM + int'(c_c)) : '0;
  assign krn_raddr = KRN_AW'(int'(kr_r) * MAX_KERNEL + int'(kc_r));

  assign ctl.clr     = start;
  assign ctl.tap_vld = tap_ok;

  assign in_rdy  = (state_r == ST_IDLE);
  assign out_vld = (state_r == ST_DONE);
  assign out_row = row_r;
  assign out_col = col_r;

endmodule

>>> src/conv2d_zero_pad_element.sv
// conv2d_zero_pad_element: zero-padded 2-D correlation at one element per query.
// A query walks T = (2*hr+1)*(2*hc+1) kernel taps (49 at most by default),
// one per cycle through the single shared multiply-accumulate, then drains the
// product register and the last accumulate; no item is taken until the result
// is delivered. Sync active-low reset sets config to defaults, idles the
// sequencer; memories not cleared.
module conv2d_zero_pad_element #(
  parameter int MAX_DIM    = cv2d_pkg::MAX_DIM_DEF,
  parameter int MAX_KERNEL = cv2d_pkg::MAX_KERNEL_DEF,
  parameter int DATA_WIDTH = cv2d_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cv2d_in_if.sink                         in_ch,
  cv2d_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [cv2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cv2d_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cv2d_pkg::*;
  `include "conv2d_zero_pad_element_assert.svh"

  localparam int IMG_AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int KRN_AW = $clog2(MAX_KERNEL * MAX_KERNEL);

  cv2d_cfg_t                    cfg_r;
  logic                         in_acc;
  logic                         q_start;
  logic                         img_we, krn_we;
  logic [IMG_AW-1:0]            img_waddr, img_raddr;
  logic [KRN_AW-1:0]            krn_waddr, krn_raddr;
  logic signed [31:0]           val_ext;
  logic [DATA_WIDTH-1:0]        wdata;
  logic signed [DATA_WIDTH-1:0] img_rdata, krn_rdata;
  cv2d_mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0]      acc;
  logic                         in_rdy, out_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mrows <= MATRIX_ROWS_RST;
      cfg_r.mcols <= MATRIX_COLS_RST;
      cfg_r.krows <= KERNEL_ROWS_RST;
      cfg_r.kcols <= KERNEL_COLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATRIX_ROWS: cfg_r.mrows <= cfg_wdata;
        CFG_MATRIX_COLS: cfg_r.mcols <= cfg_wdata;
        CFG_KERNEL_ROWS: cfg_r.krows <= cfg_wdata[KDIM_W-1:0];
        CFG_KERNEL_COLS: cfg_r.kcols <= cfg_wdata[KDIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc  = in_ch.valid && in_rdy;
  assign q_start = in_acc && (in_ch.command == CMD_QUERY);

  // value is sign-extended from 16 bits, then kept at the store width
  assign val_ext = 32'(in_ch.value);
  assign wdata   = val_ext[DATA_WIDTH-1:0];

  assign krn_we = in_acc && (in_ch.command == CMD_KRN_WR)
                  && (int'(in_ch.row) < MAX_KERNEL) && (int'(in_ch.col) < MAX_KERNEL);
  assign img_we = in_acc && (in_ch.command == CMD_IMG_WR)
                  && (int'(in_ch.row) < MAX_DIM) && (int'(in_ch.col) < MAX_DIM);
  assign krn_waddr = KRN_AW'(int'(in_ch.row) * MAX_KERNEL + int'(in_ch.col));
  assign img_waddr = IMG_AW'(int'(in_ch.row) * MAX_DIM + int'(in_ch.col));

  cv2d_store #(
    .MAX_DIM    (MAX_DIM),
    .MAX_KERNEL (MAX_KERNEL),
    .DATA_WIDTH (DATA_WIDTH),
    .IMG_AW     (IMG_AW),
    .KRN_AW     (KRN_AW)
  ) u_store (
    .clk       (clk),
    .img_we    (img_we),
    .img_waddr (img_waddr),
    .krn_we    (krn_we),
    .krn_waddr (krn_waddr),
    .wdata     (wdata),
    .img_raddr (img_raddr),
    .krn_raddr (krn_raddr),
    .img_rdata (img_rdata),
    .krn_rdata (krn_rdata)
  );

  cv2d_seq #(
    .MAX_DIM    (MAX_DIM),
    .MAX_KERNEL (MAX_KERNEL),
    .IMG_AW     (IMG_AW),
    .KRN_AW     (KRN_AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (q_start),
    .row       (in_ch.row),
    .col       (in_ch.col),
    .out_take  (out_ch.ready),
    .in_rdy    (in_rdy),
    .out_vld   (out_vld),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .ctl       (mac_ctl),
    .img_raddr (img_raddr),
    .krn_raddr (krn_raddr)
  );

  cv2d_mac #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .img_rdata (img_rdata),
    .krn_rdata (krn_rdata),
    .acc       (acc)
  );

  assign in_ch.ready     = in_rdy;
  assign out_ch.valid    = out_vld;
  assign out_ch.filtered = acc;

  // a pending result blocks new items
  `CV2D_ASSERT_IMPLY(a_busy_while_result, clk, rst_n, out_vld, !in_rdy)
  // an accepted query makes the block busy
  `CV2D_ASSERT_NEXT(a_query_goes_busy, clk, rst_n, q_start, !in_rdy)
  // once the result is taken the block is ready again
  `CV2D_ASSERT_NEXT(a_idle_after_take, clk, rst_n, out_vld && out_ch.ready, in_rdy && !out_vld)

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for conv2d_zero_pad_element: random and directed command items,
// an in-bench convolution predictor and an in-order result scoreboard.
// Depends on cv2d_pkg and the cv2d_in_if / cv2d_out_if channel interfaces.
module tb;
  import cv2d_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;  // unused code, block drops it
  localparam int IMG_N      = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int KRN_N      = MAX_KERNEL_DEF * MAX_KERNEL_DEF;
  localparam int SETTLE_CYC = 60;   // outlasts the longest query, with margin
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 150;
  localparam int ITEM_GOAL  = 750;

  typedef struct {
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [VAL_W-1:0]   value;
  } cmd_item_t;

  typedef struct {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [ACC_W-1:0]   sum;
  } pix_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cv2d_in_if  in_ch ();
  cv2d_out_if out_ch ();

  conv2d_zero_pad_element dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cmd_item_t pending_cmds[$];
  pix_t      expected_pix[$];
  pix_t      want;
  cmd_item_t nxt;

  int fail_cnt     = 0;
  int pushed_cnt   = 0;
  int accepted_cnt = 0;
  bit calm         = 0;
  bit in_fired     = 0;
  int tx_gap       = 0;
  bit tx_quiet     = 0;
  int rx_gap       = 0;
  bit rx_quiet     = 0;
  int hold_left    = 0;
  bit hold_done    = 0;

  // predictor state, updated on accepted items and config writes
  logic signed [VAL_W-1:0] img_mem [IMG_N];
  logic signed [VAL_W-1:0] krn_mem [KRN_N];
  logic [MDIM_W-1:0] p_mr = MATRIX_ROWS_RST;
  logic [MDIM_W-1:0] p_mc = MATRIX_COLS_RST;
  logic [KDIM_W-1:0] p_kr = KERNEL_ROWS_RST;
  logic [KDIM_W-1:0] p_kc = KERNEL_COLS_RST;

  // stimulus-side view: config in force and which entries hold data
  bit img_seen [IMG_N];
  bit krn_seen [KRN_N];
  logic [MDIM_W-1:0] g_mr = MATRIX_ROWS_RST;
  logic [MDIM_W-1:0] g_mc = MATRIX_COLS_RST;
  logic [KDIM_W-1:0] g_kr = KERNEL_ROWS_RST;
  logic [KDIM_W-1:0] g_kc = KERNEL_COLS_RST;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int half_span(logic [KDIM_W-1:0] k);
    int h;
    h = int'(k) / 2;
    return (h > (MAX_KERNEL_DEF - 1) / 2) ? (MAX_KERNEL_DEF - 1) / 2 : h;
  endfunction

  function automatic int dim_span(logic [MDIM_W-1:0] d);
    return (int'(d) > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(d);
  endfunction

  function automatic logic [ACC_W-1:0] conv_at(int row, int col);
    int hr, hc, nr, nc, r, c;
    longint acc;
    hr  = half_span(p_kr);
    hc  = half_span(p_kc);
    nr  = dim_span(p_mr);
    nc  = dim_span(p_mc);
    acc = 0;
    for (int i = -hr; i <= hr; i++) begin
      for (int j = -hc; j <= hc; j++) begin
        r = row + i;
        c = col + j;
        if (r >= 0 && r < nr && c >= 0 && c < nc)
          acc += longint'(krn_mem[(i + hr) * MAX_KERNEL_DEF + j + hc]) *
                 longint'(img_mem[r * MAX_DIM_DEF + c]);
      end
    end
    return ACC_W'(acc);
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
    $display("ERROR @%0t: %s got %0h exp %0h", $time, what, got, exp_v);
    fail_cnt++;
  endtask

  function automatic logic [VAL_W-1:0] rand_val();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h8000;
    if (p == 1) return 16'h7FFF;
    return VAL_W'($urandom);
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, int row, int col, logic [VAL_W-1:0] val);
    cmd_item_t it;
    it.command = cmd;
    it.row     = COORD_W'(row);
    it.col     = COORD_W'(col);
    it.value   = val;
    if (cmd == CMD_IMG_WR)
      img_seen[int'(it.row) * MAX_DIM_DEF + int'(it.col)] = 1'b1;
    if (cmd == CMD_KRN_WR && it.row < MAX_KERNEL_DEF && it.col < MAX_KERNEL_DEF)
      krn_seen[int'(it.row) * MAX_KERNEL_DEF + int'(it.col)] = 1'b1;
    pending_cmds.push_back(it);
    pushed_cnt++;
  endtask

  // write whatever the window would read that holds no data yet, then query
  task automatic add_query(int row, int col);
    int hr, hc, nr, nc, r, c, ki;
    hr = half_span(g_kr);
    hc = half_span(g_kc);
    nr = dim_span(g_mr);
    nc = dim_span(g_mc);
    for (int i = -hr; i <= hr; i++) begin
      for (int j = -hc; j <= hc; j++) begin
        r  = row + i;
        c  = col + j;
        ki = (i + hr) * MAX_KERNEL_DEF + j + hc;
        if (r >= 0 && r < nr && c >= 0 && c < nc) begin
          if (!img_seen[r * MAX_DIM_DEF + c]) queue_cmd(CMD_IMG_WR, r, c, rand_val());
          if (!krn_seen[ki]) queue_cmd(CMD_KRN_WR, i + hr, j + hc, rand_val());
        end
      end
    end
    queue_cmd(CMD_QUERY, row, col, VAL_W'($urandom));
  endtask

  task automatic settle();
    while (accepted_cnt != pushed_cnt || expected_pix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_regs(logic [CFG_DATA_W-1:0] mr, logic [CFG_DATA_W-1:0] mc,
                            logic [CFG_DATA_W-1:0] kr, logic [CFG_DATA_W-1:0] kc);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_MATRIX_ROWS; cfg_wdata <= mr;
    @(negedge clk);
    cfg_index <= CFG_MATRIX_COLS; cfg_wdata <= mc;
    @(negedge clk);
    cfg_index <= CFG_KERNEL_ROWS; cfg_wdata <= kr;
    @(negedge clk);
    cfg_index <= CFG_KERNEL_COLS; cfg_wdata <= kc;
    @(negedge clk);
    cfg_we <= 1'b0;
    g_mr = MDIM_W'(mr);
    g_mc = MDIM_W'(mc);
    g_kr = KDIM_W'(kr);
    g_kc = KDIM_W'(kc);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8)  return '0;
    if (p < 16) return CFG_DATA_W'($urandom_range(65, 127));
    if (p < 28) return CFG_DATA_W'($urandom_range(9, 64));
    return CFG_DATA_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_ksize();
    if ($urandom_range(0, 9) == 0) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, 7));
  endfunction

  // input driver: next item or an idle burst, changes only on the falling edge
  always @(negedge clk) begin
    if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!calm && !tx_quiet && $urandom_range(0, 4) == 0) begin
        tx_gap = $urandom_range(0, 3);
        in_ch.valid <= 1'b0;
      end else begin
        nxt = pending_cmds.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.command <= nxt.command;
        in_ch.row     <= nxt.row;
        in_ch.col     <= nxt.col;
        in_ch.value   <= nxt.value;
      end
    end
  end

  // result receiver: short stall bursts plus one long hold-off mid-run
  always @(negedge clk) begin
    if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ch.ready <= 1'b0;
    end else if (!calm && !rx_quiet && $urandom_range(0, 3) == 0) begin
      rx_gap = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: config and accepted items feed the predictor, results are checked in order
  always @(posedge clk) begin
    in_fired <= in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MATRIX_ROWS: p_mr = cfg_wdata[MDIM_W-1:0];
          CFG_MATRIX_COLS: p_mc = cfg_wdata[MDIM_W-1:0];
          CFG_KERNEL_ROWS: p_kr = cfg_wdata[KDIM_W-1:0];
          CFG_KERNEL_COLS: p_kc = cfg_wdata[KDIM_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        accepted_cnt++;
        case (in_ch.command)
          CMD_KRN_WR:
            if (in_ch.row < MAX_KERNEL_DEF && in_ch.col < MAX_KERNEL_DEF)
              krn_mem[int'(in_ch.row) * MAX_KERNEL_DEF + int'(in_ch.col)] = in_ch.value;
          CMD_IMG_WR:
            img_mem[int'(in_ch.row) * MAX_DIM_DEF + int'(in_ch.col)] = in_ch.value;
          CMD_QUERY:
            expected_pix.push_back('{in_ch.row, in_ch.col,
                                     conv_at(int'(in_ch.row), int'(in_ch.col))});
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pix.size() == 0) begin
          flag_mismatch("result with no query pending", out_ch.filtered, '0);
        end else begin
          want = expected_pix.pop_front();
          if (out_ch.out_row !== want.row) flag_mismatch("out_row", out_ch.out_row, want.row);
          if (out_ch.out_col !== want.col) flag_mismatch("out_col", out_ch.out_col, want.col);
          if (out_ch.filtered !== want.sum) flag_mismatch("filtered", out_ch.filtered, want.sum);
        end
      end
    end
  end

  initial begin
    int n_items, nr, hr, near_r, near_c, p;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = '0;
    in_ch.row     = '0;
    in_ch.col     = '0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    for (int i = 0; i < IMG_N; i++) img_mem[i] = '0;
    for (int i = 0; i < KRN_N; i++) krn_mem[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset config: 1x1 matrix, 3x3 kernel
    queue_cmd(CMD_KRN_WR, 1, 1, 16'h8000);
    queue_cmd(CMD_IMG_WR, 0, 0, 16'h8000);
    add_query(0, 0);
    queue_cmd(CMD_KRN_WR, 1, 1, 16'h7FFF);
    add_query(0, 0);
    queue_cmd(CMD_IMG_WR, 63, 63, 16'h7FFF);   // stored though outside the matrix
    add_query(63, 63);
    queue_cmd(CMD_KRN_WR, 7, 3, 16'h0005);     // outside the kernel store: dropped
    queue_cmd(CMD_KRN_WR, 3, 63, 16'hFFFF);
    queue_cmd(CMD_NONE, 63, 63, 16'hFFFF);
    add_query(1, 1);                           // centre outside, corner neighbor inside
    add_query(0, 0);
    settle();
    write_regs(7'd64, 7'd64, 7'd1, 7'd1);
    add_query(63, 63);
    add_query(0, 0);
    settle();
    write_regs(7'd0, 7'd64, 7'd7, 7'd7);       // empty matrix
    add_query(0, 0);
    add_query(40, 3);
    settle();
    write_regs(7'd127, 7'd2, 7'd2, 7'd0);      // oversized rows, even and zero kernel
    add_query(0, 1);
    add_query(63, 1);

    while (pushed_cnt < ITEM_GOAL) begin
      settle();
      if (pushed_cnt >= ITEM_GOAL - 130) calm = 1'b1;
      write_regs(pick_dim(), pick_dim(), pick_ksize(), pick_ksize());
      nr     = dim_span(g_mr);
      hr     = half_span(g_kr);
      near_r = ((nr > 8 ? 8 : (nr > 0 ? nr : 1)) - 1) + hr;
      nr     = dim_span(g_mc);
      hr     = half_span(g_kc);
      near_c = ((nr > 8 ? 8 : (nr > 0 ? nr : 1)) - 1) + hr;
      n_items = $urandom_range(20, 60);
      for (int k = 0; k < n_items; k++) begin
        p = $urandom_range(0, 99);
        if (p < 40) begin
          if ($urandom_range(0, 3) == 0)
            add_query($urandom_range(0, 63), $urandom_range(0, 63));
          else
            add_query($urandom_range(0, near_r), $urandom_range(0, near_c));
        end else if (p < 70) begin
          if ($urandom_range(0, 9) < 7)
            queue_cmd(CMD_IMG_WR, $urandom_range(0, near_r), $urandom_range(0, near_c),
                      rand_val());
          else
            queue_cmd(CMD_IMG_WR, $urandom_range(0, 63), $urandom_range(0, 63), rand_val());
        end else if (p < 92) begin
          if ($urandom_range(0, 9) == 0)
            queue_cmd(CMD_KRN_WR, $urandom_range(0, 63), $urandom_range(0, 63), rand_val());
          else
            queue_cmd(CMD_KRN_WR, $urandom_range(0, MAX_KERNEL_DEF - 1),
                      $urandom_range(0, MAX_KERNEL_DEF - 1), rand_val());
        end else begin
          queue_cmd(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63), VAL_W'($urandom));
        end
      end
    end
    settle();

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
